// ----- design/mcce_pkg.sv -----
package mcce_pkg;

  localparam int LETTERS     = 26;
  localparam int LETTER_BITS = 5;
  localparam int COUNT_BITS  = 64;

  localparam logic [7:0] CH_LETTER_A = 8'h41;
  localparam logic [7:0] CH_LETTER_Z = 8'h41 + 8'(LETTERS - 1);
  localparam logic [7:0] CH_OPEN     = 8'h28;
  localparam logic [7:0] CH_CLOSE    = 8'h29;

  typedef enum logic [2:0] {
    STK_NOP,
    STK_PUSH,
    STK_READ,
    STK_MERGE,
    STK_CLEAR
  } stk_op_t;

  typedef struct packed {
    logic full;
    logic few;
  } stk_stat_t;

  typedef struct packed {
    logic start;
    logic clear;
  } cost_ctl_t;

endpackage

// ----- design/mcce_if.sv -----
interface mcce_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [4:0]  letter_index;
  logic [15:0] row_count;
  logic [15:0] column_count;
  logic [7:0]  token_char;
  logic        end_of_line;

  modport source (
    output valid, action, letter_index, row_count, column_count, token_char, end_of_line,
    input  ready
  );
  modport sink (
    input  valid, action, letter_index, row_count, column_count, token_char, end_of_line,
    output ready
  );
endinterface

interface mcce_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] multiply_count;
  logic        mismatch_error;

  modport source (
    output valid, multiply_count, mismatch_error,
    input  ready
  );
  modport sink (
    input  valid, multiply_count, mismatch_error,
    output ready
  );
endinterface

// ----- design/matrix_chain_cost_evaluator_top.sv -----
// Matrix chain cost evaluator.
// in_ch carries one item per handshake (valid and ready high at a rising edge).
// A define item (action 0) writes the rows and columns of one letter into the
// dimension table; an index above 25 is dropped. A token item (action 1) holds
// one character: a letter pushes its dimensions, ')' combines the two top
// operands and adds rows*inner*cols to the line count, anything else is skipped.
// On a token item with end_of_line set, one result item goes out on out_ch:
// the saturating count, or mismatch_error with a zero count.
// Steps per item: a define or skipped character needs none beyond its handshake;
// a letter does a table read, then a stack write; ')' does a stack read, a compare,
// then the three-step multiply and the accumulate in the cost unit; end of line adds
// a load of the output register. Everything runs through the one stack memory port
// pair, so items are taken one at a time; ready is high only while the control is idle.
// Reset clears the stack depth, the count, the error flag and the output valid;
// the table and stack memories hold whatever they held.
// A stalled receiver keeps the result in the output register. Items keep being
// accepted until a second end of line finds that register still full; the
// block then holds ready low until the result is taken.
module matrix_chain_cost_evaluator_top
  import mcce_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int DIM_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  mcce_in_if.sink           in_ch,
  mcce_out_if.source        out_ch
);

  localparam int DW = 2 * DIM_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_CLOSE,
    S_COST,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_OTHER,
    K_CLOSE,
    K_LETTER
  } tok_kind_t;

  state_t                state;
  logic                  err;
  logic                  eol_pend;

  logic                  accept;
  logic                  is_tok;
  tok_kind_t             kind;
  logic [7:0]            tok_off;
  logic [DIM_BITS+15:0]  rows_wide, cols_wide;
  logic                  tbl_wr;
  logic [DW-1:0]         tbl_rdata;
  stk_op_t               stk_op;
  logic [DW-1:0]         stk_data;
  stk_stat_t             stk_stat;
  logic [DW-1:0]         stk_top, stk_below;
  cost_ctl_t             cost_ctl;
  logic                  cost_done;
  logic [COUNT_BITS-1:0] cost_total;
  logic [DIM_BITS-1:0]   a_rows, a_cols, b_rows, b_cols;
  logic                  dims_match;
  logic                  emit_ok;
  state_t                after_in, after_pend;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_tok      = accept && in_ch.action;
  assign tok_off     = in_ch.token_char - CH_LETTER_A;
  assign rows_wide   = {DIM_BITS'(0), in_ch.row_count};
  assign cols_wide   = {DIM_BITS'(0), in_ch.column_count};

  assign a_rows     = stk_below[DW-1:DIM_BITS];
  assign a_cols     = stk_below[DIM_BITS-1:0];
  assign b_rows     = stk_top[DW-1:DIM_BITS];
  assign b_cols     = stk_top[DIM_BITS-1:0];
  assign dims_match = (a_cols == b_rows);
  assign emit_ok    = !out_ch.valid || out_ch.ready;
  assign after_in   = in_ch.end_of_line ? S_EMIT : S_IDLE;
  assign after_pend = eol_pend ? S_EMIT : S_IDLE;

  always_comb begin
    case (in_ch.token_char) inside
      CH_CLOSE:                  kind = K_CLOSE;
      CH_OPEN:                   kind = K_OTHER;
      [CH_LETTER_A:CH_LETTER_Z]: kind = K_LETTER;
      default:                   kind = K_OTHER;
    endcase
  end

  always_comb begin
    tbl_wr   = 1'b0;
    stk_op   = STK_NOP;
    stk_data = '0;
    cost_ctl = '0;
    unique case (state)
      S_IDLE: begin
        tbl_wr = accept && !in_ch.action && (in_ch.letter_index < LETTER_BITS'(LETTERS));
        if (is_tok && !err && kind == K_CLOSE && !stk_stat.few) begin
          stk_op = STK_READ;
        end
      end
      S_PUSH: begin
        stk_op   = STK_PUSH;
        stk_data = tbl_rdata;
      end
      S_CLOSE: begin
        if (dims_match) begin
          stk_op         = STK_MERGE;
          stk_data       = {a_rows, b_cols};
          cost_ctl.start = 1'b1;
        end
      end
      S_COST: ;
      S_EMIT: begin
        if (emit_ok) begin
          stk_op         = STK_CLEAR;
          cost_ctl.clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      err          <= 1'b0;
      eol_pend     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_EMIT) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (is_tok) begin
            eol_pend <= in_ch.end_of_line;
            state    <= after_in;
            if (!err) begin
              case (kind)
                K_CLOSE: begin
                  if (stk_stat.few) begin
                    err <= 1'b1;
                  end else begin
                    state <= S_CLOSE;
                  end
                end
                K_LETTER: begin
                  if (stk_stat.full) begin
                    err <= 1'b1;
                  end else begin
                    state <= S_PUSH;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_PUSH: state <= after_pend;
        S_CLOSE: begin
          if (dims_match) begin
            state <= S_COST;
          end else begin
            err   <= 1'b1;
            state <= after_pend;
          end
        end
        S_COST: begin
          if (cost_done) begin
            state <= after_pend;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_ch.valid          <= 1'b1;
            out_ch.multiply_count <= err ? '0 : cost_total;
            out_ch.mismatch_error <= err;
            err                   <= 1'b0;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  mcce_dim_table #(
    .DIM_BITS (DIM_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_ch.letter_index),
    .wr_data ({rows_wide[DIM_BITS-1:0], cols_wide[DIM_BITS-1:0]}),
    .rd_addr (tok_off[LETTER_BITS-1:0]),
    .rd_data (tbl_rdata)
  );

  mcce_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .DIM_BITS    (DIM_BITS)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .op      (stk_op),
    .wr_data (stk_data),
    .stat    (stk_stat),
    .top     (stk_top),
    .below   (stk_below)
  );

  mcce_cost_unit #(
    .DIM_BITS (DIM_BITS)
  ) u_cost (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cost_ctl),
    .rows  (a_rows),
    .inner (a_cols),
    .cols  (b_cols),
    .done  (cost_done),
    .total (cost_total)
  );

endmodule

// ----- design/mcce_dim_table.sv -----
module mcce_dim_table
  import mcce_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [LETTER_BITS-1:0]  wr_addr,
  input  logic [2*DIM_BITS-1:0]   wr_data,
  input  logic [LETTER_BITS-1:0]  rd_addr,
  output logic [2*DIM_BITS-1:0]   rd_data
);

  logic [2*DIM_BITS-1:0] mem [LETTERS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/mcce_stack.sv -----
module mcce_stack
  import mcce_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int DIM_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stk_op_t               op,
  input  logic [2*DIM_BITS-1:0] wr_data,
  output stk_stat_t             stat,
  output logic [2*DIM_BITS-1:0] top,
  output logic [2*DIM_BITS-1:0] below
);

  localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  logic [2*DIM_BITS-1:0] mem [STACK_DEPTH];
  logic [DEPTH_W-1:0]    depth;
  logic [DEPTH_W-1:0]    below_idx;

  assign below_idx = depth - DEPTH_W'(2);
  assign stat.full = (depth == DEPTH_W'(STACK_DEPTH));
  assign stat.few  = (depth < DEPTH_W'(2));

  always_ff @(posedge clk) begin
    case (op)
      STK_PUSH:  mem[depth[ADDR_W-1:0]] <= wr_data;
      STK_MERGE: mem[below_idx[ADDR_W-1:0]] <= wr_data;
      default: ;
    endcase
    if (op == STK_READ) begin
      below <= mem[below_idx[ADDR_W-1:0]];
    end
    if (op == STK_PUSH || op == STK_MERGE) begin
      top <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      case (op)
        STK_PUSH:  depth <= depth + DEPTH_W'(1);
        STK_MERGE: depth <= depth - DEPTH_W'(1);
        STK_CLEAR: depth <= '0;
        default: ;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (op == STK_PUSH) |-> !stat.full)
    else $error("push onto full stack");

  a_merge_after_read: assert property (@(posedge clk) disable iff (rst)
    (op == STK_MERGE) |-> ($past(op) == STK_READ && !stat.few))
    else $error("merge without preceding read");

endmodule

// ----- design/mcce_cost_unit.sv -----
module mcce_cost_unit
  import mcce_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cost_ctl_t             ctl,
  input  logic [DIM_BITS-1:0]   rows,
  input  logic [DIM_BITS-1:0]   inner,
  input  logic [DIM_BITS-1:0]   cols,
  output logic                  done,
  output logic [COUNT_BITS-1:0] total
);

  localparam int PW = 2 * DIM_BITS;

  logic                  v1, v2, v3;
  logic [PW-1:0]         p1;
  logic [DIM_BITS-1:0]   c1;
  logic [PW-1:0]         pp_lo, pp_hi;
  logic [COUNT_BITS-1:0] prod;
  logic [COUNT_BITS:0]   sum;

  assign sum = {1'b0, total} + {1'b0, prod};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      p1 <= PW'(rows) * PW'(inner);
      c1 <= cols;
    end
    if (v1) begin
      pp_lo <= PW'(p1[DIM_BITS-1:0]) * PW'(c1);
      pp_hi <= PW'(p1[PW-1:DIM_BITS]) * PW'(c1);
    end
    if (v2) begin
      prod <= (COUNT_BITS'(pp_hi) << DIM_BITS) + COUNT_BITS'(pp_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      done  <= 1'b0;
      total <= '0;
    end else begin
      v1   <= ctl.start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
      if (ctl.clear) begin
        total <= '0;
      end else if (v3) begin
        total <= sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      end
    end
  end

endmodule
